// File: rtl/lses_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lses_pkg: shared types and constants for the LED strip effect sequencer
// Request payloads, controller/datapath handshake structs and fixed codes.
// ----------------------------------------------------------------------------
package lses_pkg;

    localparam int MAX_LEDS   = 32;
    localparam int IDX_W      = 5;
    localparam int COLOR_W    = 24;
    localparam int KIND_W     = 3;
    localparam int CMD_W      = 2;
    localparam int MASK_W     = 32;
    localparam int CNT_W      = 6;
    localparam int SSTEP_W    = 8;
    localparam int DUR_W      = 16;
    localparam int PHASE_W    = 7;
    localparam int LEVEL_W    = 7;
    localparam int ROUND_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ON     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OFF    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SCROLL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIMM   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_STATUS = 3'd5;

    // strip commands as kept in the queue
    localparam logic [CMD_W-1:0] CMD_ON     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_OFF    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DIMM   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_DUR  = 2'd2;

    localparam logic [CNT_W-1:0]   LED_COUNT_RST   = 6'd12;
    localparam logic [SSTEP_W-1:0] SCROLL_STEP_RST = 8'd10;
    localparam logic [DUR_W-1:0]   SCROLL_DUR_RST  = 16'd500;

    localparam logic [COLOR_W-1:0] WHITE       = 24'hFF_FFFF;
    localparam logic [COLOR_W-1:0] RED_MASK    = 24'hFF_0000;
    localparam logic [COLOR_W-1:0] GREEN_MASK  = 24'h00_FF00;
    localparam logic [COLOR_W-1:0] BLUE_MASK   = 24'h00_00FF;
    localparam logic [MASK_W-1:0]  PATTERN_ALL = 32'hFFFF_FFFF;
    localparam logic [MASK_W-1:0]  SWEEP_START = 32'h0000_0003;

    // dimm ramp: 100 levels per round, three rounds
    localparam logic [LEVEL_W-1:0] DIMM_LAST_LEVEL = 7'd99;
    localparam logic [LEVEL_W-1:0] DIMM_HALF       = 7'd50;
    localparam logic [ROUND_W-1:0] DIMM_ROUNDS    = 2'd3;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_SCROLL = 3'b010,
        MODE_DIMM   = 3'b100
    } mode_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COLOR_W-1:0] color;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   led_index;
        logic [COLOR_W-1:0] led_color;
        logic               last_in_frame;
        logic               is_frame;
        logic               lights_on_flag;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic run_cmd;
        logic run_tick;
        logic run_status;
        logic run_pop;
        logic emit_adv;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              can_pop;
        logic              frame_pend;
        logic              last_out;
    } dp_stat_t;

    // triangle ramp: 0,2,..,98 then 100,98,..,2
    function automatic logic [7:0] dimm_level(input logic [LEVEL_W-1:0] r);
        logic [7:0] r2;
        r2 = {r, 1'b0};
        if (r < DIMM_HALF) begin
            dimm_level = r2;
        end else begin
            dimm_level = 8'd200 - r2;
        end
    endfunction

endpackage

// File: rtl/led_strip_effect_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_effect_sequencer_top: LED strip effect sequencer
// Order: a strip command passes dispatch and check before its first result, a tick
//   dispatch, pop and check, a status reply dispatch alone; one request at a time.
// Throughput: one result per cycle while out_ready is high.
// Reset: rst_n asynchronous, active low; effect state, queue and config
//   registers return to their defaults at once, no clearing pass.
// ----------------------------------------------------------------------------
module led_strip_effect_sequencer_top
    import lses_pkg::*;
#(
    parameter int FIFO_DEPTH = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Controller/datapath split:
    //  - lses_ctrl takes one request at a time (in_ready only while idle),
    //    dispatches it, optionally pops a queued strip command after a tick,
    //    and then streams the frame.
    //  - lses_dp holds all effect state. On/scroll latch their color at
    //    once; strip commands that find an animation running or a non-empty
    //    queue go into the command queue (dropped when full).
    //  - Results come straight from datapath registers, so the payload holds
    //    steady while out_valid waits on out_ready.

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    lses_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    lses_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // a new request is never taken while a frame is still streaming
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request accepted during frame output");

    // a status reply is a single result at index zero with black color
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.is_frame) |->
        (out_data.last_in_frame && out_data.led_index == '0 && out_data.led_color == '0))
        else $error("malformed status reply");

    // the frame keeps streaming until its last LED has gone out
    a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_in_frame) |=> out_valid)
        else $error("frame cut short");

    // after the final result the block is ready for the next request
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_in_frame) |=> in_ready)
        else $error("not idle after last result");
`endif

endmodule

// File: rtl/lses_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lses_ctrl: request sequencer
// Accepts one request, steps the datapath through dispatch, queue pop and
// frame streaming, then returns to idle.
// ----------------------------------------------------------------------------
module lses_ctrl
    import lses_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_POP      = 5'b00100,
        S_CHECK    = 5'b01000,
        S_EMIT     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.kind)
                    KIND_ON, KIND_OFF, KIND_SCROLL, KIND_DIMM:
                    begin
                        cmd.run_cmd = 1'b1;
                        state_next  = S_CHECK;
                    end
                    KIND_TICK:
                    begin
                        cmd.run_tick = 1'b1;
                        state_next   = S_POP;
                    end
                    KIND_STATUS:
                    begin
                        cmd.run_status = 1'b1;
                        state_next     = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.run_pop = stat.can_pop;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = stat.frame_pend ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit_adv = 1'b1;
                    if (stat.last_out)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/lses_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lses_dp: effect datapath
// Config registers, command queue, scroll/dimm animation state and the
// frame generator that walks the LEDs one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module lses_dp
    import lses_pkg::*;
#(
    parameter int FIFO_DEPTH = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_item_t              in_data,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output out_item_t             out_data
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FCNT_W-1:0] FCNT_FULL = FCNT_W'(FIFO_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [CNT_W-1:0]   led_count_reg;
    logic [SSTEP_W-1:0] scroll_step_reg;
    logic [DUR_W-1:0]   scroll_dur_reg;

    // captured request
    logic [KIND_W-1:0]  item_kind_reg;
    logic [COLOR_W-1:0] item_color_reg;

    // effect state
    logic [COLOR_W-1:0] stored_color_reg, stored_color_next;
    logic               lights_on_reg, lights_on_next;
    mode_t              mode_reg, mode_next;
    logic [COLOR_W-1:0] scroll_color_reg, scroll_color_next;
    logic [MASK_W-1:0]  scroll_mask_reg, scroll_mask_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [SSTEP_W-1:0] wait_reg, wait_next;
    logic [DUR_W-1:0]   elapsed_reg, elapsed_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [COLOR_W-1:0] chan_mask_reg, chan_mask_next;

    // command queue
    logic [CMD_W-1:0]   fifo_mem [FIFO_DEPTH];
    logic [CMD_W-1:0]   head_cmd_reg;   // registered read of the queue head
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic               push_en;

    // frame generator
    logic               frame_pend_reg, frame_pend_next;
    logic               is_status_reg, is_status_next;
    logic [COLOR_W-1:0] frame_color_reg, frame_color_next;
    logic [MASK_W-1:0]  frame_pat_reg, frame_pat_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    // derived
    logic [CNT_W-1:0]   cnt_eff;
    logic [CNT_W-1:0]   cnt_m1;
    logic [PHASE_W-1:0] sweep_end;
    logic [SSTEP_W-1:0] step_eff;
    logic               last_out;

    logic               do_start;
    logic [CMD_W-1:0]   start_cmd;
    logic [COLOR_W-1:0] start_color;
    logic [SSTEP_W-1:0] wait_inc;
    logic [PHASE_W-1:0] phase_inc;
    logic [MASK_W-1:0]  mask_sh;
    logic [7:0]         lvl;

    always_comb
    begin
        if (led_count_reg == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (led_count_reg > CNT_W'(MAX_LEDS))
        begin
            cnt_eff = CNT_W'(MAX_LEDS);
        end
        else
        begin
            cnt_eff = led_count_reg;
        end
    end

    assign cnt_m1    = cnt_eff - 1'b1;
    assign sweep_end = {cnt_eff, 1'b0} - 1'b1;
    assign step_eff  = (scroll_step_reg == '0) ? SSTEP_W'(1) : scroll_step_reg;
    assign last_out  = is_status_reg || ({1'b0, idx_reg} == cnt_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg   <= LED_COUNT_RST;
            scroll_step_reg <= SCROLL_STEP_RST;
            scroll_dur_reg  <= SCROLL_DUR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LED_COUNT:   led_count_reg   <= cfg_data[CNT_W-1:0];
                CFG_SCROLL_STEP: scroll_step_reg <= cfg_data[SSTEP_W-1:0];
                CFG_SCROLL_DUR:  scroll_dur_reg  <= cfg_data[DUR_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        stored_color_next = stored_color_reg;
        lights_on_next    = lights_on_reg;
        mode_next         = mode_reg;
        scroll_color_next = scroll_color_reg;
        scroll_mask_next  = scroll_mask_reg;
        phase_next        = phase_reg;
        wait_next         = wait_reg;
        elapsed_next      = elapsed_reg;
        level_next        = level_reg;
        round_next        = round_reg;
        chan_mask_next    = chan_mask_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        fcnt_next         = fcnt_reg;
        frame_pend_next   = frame_pend_reg;
        is_status_next    = is_status_reg;
        frame_color_next  = frame_color_reg;
        frame_pat_next    = frame_pat_reg;
        idx_next          = idx_reg;
        push_en           = 1'b0;
        do_start          = 1'b0;
        start_cmd         = item_kind_reg[CMD_W-1:0];
        start_color       = stored_color_reg;
        wait_inc          = wait_reg + 1'b1;
        phase_inc         = phase_reg + 1'b1;
        mask_sh           = ({1'b0, phase_reg} < {2'b00, cnt_m1})
                            ? (scroll_mask_reg << 1) : (scroll_mask_reg >> 1);
        lvl               = '0;

        if (cmd.run_cmd)
        begin
            if (item_kind_reg == KIND_ON || item_kind_reg == KIND_SCROLL)
            begin
                stored_color_next = item_color_reg;
                start_color       = item_color_reg;
            end
            if (mode_reg == MODE_IDLE && fcnt_reg == '0)
            begin
                do_start = 1'b1;
            end
            else if (fcnt_reg != FCNT_FULL)
            begin
                push_en   = 1'b1;
                tail_next = ptr_inc(tail_reg);
                fcnt_next = fcnt_reg + 1'b1;
            end
        end

        if (cmd.run_pop)
        begin
            do_start  = 1'b1;
            start_cmd = head_cmd_reg;
            head_next = ptr_inc(head_reg);
            fcnt_next = fcnt_reg - 1'b1;
        end

        if (cmd.run_tick)
        begin
            case (mode_reg)
                MODE_SCROLL:
                begin
                    if (elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + 1'b1;
                    end
                    if (wait_inc >= step_eff)
                    begin
                        wait_next        = '0;
                        scroll_mask_next = mask_sh;
                        phase_next       = phase_inc;
                        if (phase_inc >= sweep_end)
                        begin
                            if (elapsed_next < scroll_dur_reg)
                            begin
                                scroll_mask_next = SWEEP_START;
                                phase_next       = '0;
                                frame_pend_next  = 1'b1;
                                is_status_next   = 1'b0;
                                frame_color_next = scroll_color_reg;
                                frame_pat_next   = SWEEP_START;
                                idx_next         = '0;
                            end
                            else
                            begin
                                mode_next      = MODE_IDLE;
                                lights_on_next = 1'b0;
                            end
                        end
                        else
                        begin
                            frame_pend_next  = 1'b1;
                            is_status_next   = 1'b0;
                            frame_color_next = scroll_color_reg;
                            frame_pat_next   = mask_sh;
                            idx_next         = '0;
                        end
                    end
                    else
                    begin
                        wait_next = wait_inc;
                    end
                end
                MODE_DIMM:
                begin
                    if (level_reg == DIMM_LAST_LEVEL)
                    begin
                        level_next = '0;
                        round_next = round_reg + 1'b1;
                    end
                    else
                    begin
                        level_next = level_reg + 1'b1;
                    end
                    if (round_next == DIMM_ROUNDS)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        lvl              = dimm_level(level_next);
                        frame_pend_next  = 1'b1;
                        is_status_next   = 1'b0;
                        frame_color_next = {lvl, lvl, lvl} & chan_mask_reg;
                        frame_pat_next   = PATTERN_ALL;
                        idx_next         = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.run_status)
        begin
            frame_pend_next = 1'b1;
            is_status_next  = 1'b1;
            idx_next        = '0;
        end

        if (do_start)
        begin
            frame_pend_next = 1'b1;
            is_status_next  = 1'b0;
            frame_pat_next  = PATTERN_ALL;
            idx_next        = '0;
            case (start_cmd)
                CMD_ON:
                begin
                    lights_on_next   = 1'b1;
                    frame_color_next = start_color;
                end
                CMD_OFF:
                begin
                    lights_on_next   = 1'b0;
                    frame_color_next = '0;
                end
                CMD_SCROLL:
                begin
                    scroll_color_next = start_color;
                    elapsed_next      = '0;
                    wait_next         = '0;
                    if (scroll_dur_reg == '0)
                    begin
                        lights_on_next  = 1'b0;
                        frame_pend_next = 1'b0;
                    end
                    else
                    begin
                        lights_on_next   = 1'b1;
                        mode_next        = MODE_SCROLL;
                        scroll_mask_next = SWEEP_START;
                        phase_next       = '0;
                        frame_color_next = start_color;
                        frame_pat_next   = SWEEP_START;
                    end
                end
                default:
                begin
                    lights_on_next = 1'b1;
                    chan_mask_next = '0;
                    if ((start_color & RED_MASK) != '0)
                    begin
                        chan_mask_next = chan_mask_next | RED_MASK;
                    end
                    if ((start_color & GREEN_MASK) != '0)
                    begin
                        chan_mask_next = chan_mask_next | GREEN_MASK;
                    end
                    if ((start_color & BLUE_MASK) != '0)
                    begin
                        chan_mask_next = chan_mask_next | BLUE_MASK;
                    end
                    level_next       = '0;
                    round_next       = '0;
                    mode_next        = MODE_DIMM;
                    frame_color_next = '0;   // ramp starts at level zero
                end
            endcase
        end

        if (cmd.emit_adv)
        begin
            if (last_out)
            begin
                frame_pend_next = 1'b0;
                is_status_next  = 1'b0;
                idx_next        = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_color_reg <= WHITE;
            lights_on_reg    <= 1'b0;
            mode_reg         <= MODE_IDLE;
            scroll_color_reg <= '0;
            scroll_mask_reg  <= '0;
            phase_reg        <= '0;
            wait_reg         <= '0;
            elapsed_reg      <= '0;
            level_reg        <= '0;
            round_reg        <= '0;
            chan_mask_reg    <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fcnt_reg         <= '0;
            frame_pend_reg   <= 1'b0;
            is_status_reg    <= 1'b0;
            idx_reg          <= '0;
        end
        else
        begin
            stored_color_reg <= stored_color_next;
            lights_on_reg    <= lights_on_next;
            mode_reg         <= mode_next;
            scroll_color_reg <= scroll_color_next;
            scroll_mask_reg  <= scroll_mask_next;
            phase_reg        <= phase_next;
            wait_reg         <= wait_next;
            elapsed_reg      <= elapsed_next;
            level_reg        <= level_next;
            round_reg        <= round_next;
            chan_mask_reg    <= chan_mask_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fcnt_reg         <= fcnt_next;
            frame_pend_reg   <= frame_pend_next;
            is_status_reg    <= is_status_next;
            idx_reg          <= idx_next;
        end
    end

    // payload registers, no reset
    // a pushed entry waits through the check, idle and a tick's dispatch state
    // before it can be popped, so the head read register always holds it by then
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_kind_reg  <= in_data.kind;
            item_color_reg <= in_data.color;
        end
        if (push_en)
        begin
            fifo_mem[tail_reg] <= item_kind_reg[CMD_W-1:0];
        end
        head_cmd_reg    <= fifo_mem[head_reg];
        frame_color_reg <= frame_color_next;
        frame_pat_reg   <= frame_pat_next;
    end

    assign stat.kind       = item_kind_reg;
    assign stat.can_pop    = (mode_reg == MODE_IDLE) && !frame_pend_reg && (fcnt_reg != '0);
    assign stat.frame_pend = frame_pend_reg;
    assign stat.last_out   = last_out;

    assign out_data.led_index      = is_status_reg ? '0 : idx_reg;
    assign out_data.led_color      = (!is_status_reg && frame_pat_reg[idx_reg])
                                     ? frame_color_reg : '0;
    assign out_data.last_in_frame  = last_out;
    assign out_data.is_frame       = !is_status_reg;
    assign out_data.lights_on_flag = lights_on_reg;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the LED strip effect sequencer
// Drives requests (on, off, scroll, dimm, tick, status, unused kinds) through
// several register settings, predicts every frame and status reply in a
// scoreboard object, and checks each result field by field in order.
// ----------------------------------------------------------------------------
module testbench;

    import lses_pkg::*;

    localparam int unsigned FIFO_SLOTS    = 10;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned DRAIN_CYCLES  = 8;    // idle time before a register write
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off
    localparam int unsigned TIMEOUT_NS    = 20_000_000;
    localparam int unsigned RAMP_PERIOD   = 100;  // dimm levels per round
    localparam int unsigned RAMP_HALF     = 50;
    localparam int unsigned RAMP_FRAMES   = 300;  // three rounds
    localparam int unsigned ELAPSED_MAX   = 65535;

    // kinds the block must ignore
    localparam logic [KIND_W-1:0]    KIND_RSVD_A = 3'd6;
    localparam logic [KIND_W-1:0]    KIND_RSVD_B = 3'd7;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    typedef enum int unsigned { RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM } rx_style_t;

    // ------------------------------------------------------------------------
    // Scoreboard: owns a copy of the strip state and the register values,
    // turns each accepted request into the results it should cause, and
    // matches results against them in order.
    // ------------------------------------------------------------------------
    class strip_scoreboard;
        logic [CNT_W-1:0]   led_count_reg;
        logic [SSTEP_W-1:0] step_reg;
        logic [DUR_W-1:0]   dur_reg;

        logic [COLOR_W-1:0] held_color;
        logic               lit;
        mode_t              effect;
        logic [CMD_W-1:0]   cmd_backlog[$];
        logic [COLOR_W-1:0] sweep_color;
        logic [MASK_W-1:0]  sweep_mask;
        int unsigned        sweep_pos;
        int unsigned        step_wait;
        int unsigned        elapsed;
        int unsigned        ramp_pos;
        logic [COLOR_W-1:0] ramp_channels;

        out_item_t          pixels_due[$];
        out_item_t          frame_buf[$];
        int unsigned        errors;

        function new();
            led_count_reg = LED_COUNT_RST;
            step_reg      = SCROLL_STEP_RST;
            dur_reg       = SCROLL_DUR_RST;
            held_color    = WHITE;
            lit           = 1'b0;
            effect        = MODE_IDLE;
            sweep_color   = '0;
            sweep_mask    = '0;
            sweep_pos     = 0;
            step_wait     = 0;
            elapsed       = 0;
            ramp_pos      = 0;
            ramp_channels = '0;
            errors        = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_LED_COUNT:   led_count_reg = value[CNT_W-1:0];
                CFG_SCROLL_STEP: step_reg      = value[SSTEP_W-1:0];
                CFG_SCROLL_DUR:  dur_reg       = value[DUR_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned strip_len();
            if (led_count_reg == 0) return 1;
            if (led_count_reg > MAX_LEDS) return MAX_LEDS;
            return led_count_reg;
        endfunction

        function void push_frame(logic [COLOR_W-1:0] shade, logic [MASK_W-1:0] pattern);
            out_item_t   px;
            int unsigned n;
            int unsigned i;
            n = strip_len();
            for (i = 0; i < n; i++) begin
                px.led_index      = i[IDX_W-1:0];
                px.led_color      = pattern[i] ? shade : '0;
                px.last_in_frame  = (i == n - 1);
                px.is_frame       = 1'b1;
                px.lights_on_flag = 1'b0;
                frame_buf.push_back(px);
            end
        endfunction

        // triangle ramp on the channels that were lit when dimm started
        function void push_ramp();
            int unsigned lvl;
            logic [7:0]  c;
            lvl = ramp_pos % RAMP_PERIOD;
            c = 8'((lvl < RAMP_HALF) ? 2 * lvl : RAMP_PERIOD - 2 * (lvl - RAMP_HALF));
            push_frame({c, c, c} & ramp_channels, PATTERN_ALL);
        endfunction

        function void run_command(logic [CMD_W-1:0] cmd);
            case (cmd)
                CMD_ON:
                begin
                    lit = 1'b1;
                    push_frame(held_color, PATTERN_ALL);
                end
                CMD_OFF:
                begin
                    lit = 1'b0;
                    push_frame('0, PATTERN_ALL);
                end
                CMD_SCROLL:
                begin
                    lit         = 1'b1;
                    sweep_color = held_color;
                    elapsed     = 0;
                    step_wait   = 0;
                    if (dur_reg == 0) begin
                        lit = 1'b0;
                    end else begin
                        effect     = MODE_SCROLL;
                        sweep_mask = SWEEP_START;
                        sweep_pos  = 0;
                        push_frame(sweep_color, sweep_mask);
                    end
                end
                default:
                begin
                    lit = 1'b1;
                    ramp_channels = (((held_color & RED_MASK)   != 0) ? RED_MASK   : '0)
                                  | (((held_color & GREEN_MASK) != 0) ? GREEN_MASK : '0)
                                  | (((held_color & BLUE_MASK)  != 0) ? BLUE_MASK  : '0);
                    ramp_pos = 0;
                    effect   = MODE_DIMM;
                    push_ramp();
                end
            endcase
        endfunction

        function void advance_tick();
            int unsigned stride;
            int unsigned n;
            if (effect == MODE_SCROLL) begin
                stride = (step_reg == 0) ? 1 : step_reg;
                n = strip_len();
                if (elapsed < ELAPSED_MAX) elapsed++;
                step_wait++;
                if (step_wait >= stride) begin
                    step_wait = 0;
                    if (sweep_pos < n - 1) sweep_mask = sweep_mask << 1;
                    else sweep_mask = sweep_mask >> 1;
                    sweep_pos++;
                    if (sweep_pos >= 2 * n - 1) begin
                        if (elapsed < dur_reg) begin
                            sweep_mask = SWEEP_START;
                            sweep_pos  = 0;
                            push_frame(sweep_color, sweep_mask);
                        end else begin
                            effect = MODE_IDLE;
                            lit    = 1'b0;
                        end
                    end else begin
                        push_frame(sweep_color, sweep_mask);
                    end
                end
            end else if (effect == MODE_DIMM) begin
                ramp_pos++;
                if (ramp_pos >= RAMP_FRAMES) effect = MODE_IDLE;
                else push_ramp();
            end
            // an idle tick, or one that closes an effect silently, runs one queued command
            if (effect == MODE_IDLE && frame_buf.size() == 0 && cmd_backlog.size() != 0)
                run_command(cmd_backlog.pop_front());
        endfunction

        function void take_request(in_item_t req);
            out_item_t   reply;
            int unsigned k;
            frame_buf.delete();
            case (req.kind)
                KIND_ON, KIND_OFF, KIND_SCROLL, KIND_DIMM:
                begin
                    // color is latched even when the command is queued or dropped
                    if (req.kind == KIND_ON || req.kind == KIND_SCROLL) held_color = req.color;
                    if (effect == MODE_IDLE && cmd_backlog.size() == 0)
                        run_command(req.kind[CMD_W-1:0]);
                    else if (cmd_backlog.size() < FIFO_SLOTS)
                        cmd_backlog.push_back(req.kind[CMD_W-1:0]);
                end
                KIND_TICK: advance_tick();
                KIND_STATUS:
                begin
                    reply = '0;
                    reply.last_in_frame = 1'b1;
                    frame_buf.push_back(reply);
                end
                default: ;
            endcase
            for (k = 0; k < frame_buf.size(); k++) begin
                frame_buf[k].lights_on_flag = lit;
                pixels_due.push_back(frame_buf[k]);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            if (pixels_due.size() == 0) begin
                $error("result with none expected: led_index %0d led_color 0x%06h",
                       got.led_index, got.led_color);
                errors++;
                return;
            end
            want = pixels_due.pop_front();
            compare_field("led_index", 32'(want.led_index), 32'(got.led_index));
            compare_field("led_color", 32'(want.led_color), 32'(got.led_color));
            compare_field("last_in_frame", 32'(want.last_in_frame), 32'(got.last_in_frame));
            compare_field("is_frame", 32'(want.is_frame), 32'(got.is_frame));
            compare_field("lights_on_flag", 32'(want.lights_on_flag),
                          32'(got.lights_on_flag));
        endfunction

        function int unsigned pending();
            return pixels_due.size();
        endfunction

        function bit busy();
            return effect != MODE_IDLE;
        endfunction

        function int unsigned backlog();
            return cmd_backlog.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    strip_scoreboard board = new();
    int unsigned     burst_left = 0;
    bit              hold_off_req = 1'b0;

    always #6 clk = ~clk;

    led_strip_effect_sequencer_top #(
        .FIFO_DEPTH (FIFO_SLOTS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Results are sampled at the rising edge; out_ready only moves on the falling one.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_pixel(out_data);
    end

    // ------------------------------------------------------------------------
    // Receiver: stretches of different stall styles; on request, one long
    // hold-off so the block backs up into its request channel.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned span;
        int unsigned k;
        rx_style_t   style;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                repeat (HOLD_CYCLES) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
                hold_off_req = 1'b0;
            end
            style = rx_style_t'($urandom_range(3));
            span  = $urandom_range(8, 80);
            for (k = 0; k < span; k++) begin
                @(negedge clk);
                case (style)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(1));
                    RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
                    default:   out_ready <= (k % 3 != 2);
                endcase
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Request driving
    // ------------------------------------------------------------------------
    function automatic in_item_t req_of(input logic [KIND_W-1:0] kind,
                                        input logic [COLOR_W-1:0] color);
        in_item_t req;
        req.kind  = kind;
        req.color = color;
        return req;
    endfunction

    // Holds valid until accepted, then either keeps the burst going or idles.
    task automatic offer(input in_item_t req);
        int unsigned gap;
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        board.take_request(req);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(0, 15);
        end
    endtask

    // Sender stops and waits for every expected result, plus optional idle time.
    task automatic wait_results(input int unsigned extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_register(idx, value);
    endtask

    // Mostly ticks while an effect runs, mostly commands when idle.
    function automatic in_item_t pick_request(input int unsigned w_scroll,
                                              input int unsigned w_dimm);
        in_item_t    req;
        int unsigned roll;
        int unsigned tick_end;
        int unsigned cmd_end;
        int unsigned status_end;
        int unsigned cmd_roll;
        req.color = COLOR_W'($urandom());
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(4))
                0:       req.color = '0;
                1:       req.color = WHITE;
                2:       req.color = RED_MASK;
                3:       req.color = GREEN_MASK;
                default: req.color = BLUE_MASK;
            endcase
        end
        if (board.busy()) begin
            tick_end = 78; cmd_end = 92; status_end = 97;
        end else begin
            tick_end = 30; cmd_end = 85; status_end = 95;
        end
        roll = $urandom_range(99);
        if (roll < tick_end) begin
            req.kind = KIND_TICK;
        end else if (roll < cmd_end) begin
            cmd_roll = $urandom_range(99);
            if (cmd_roll < w_dimm) req.kind = KIND_DIMM;
            else if (cmd_roll < w_dimm + w_scroll) req.kind = KIND_SCROLL;
            else req.kind = $urandom_range(1) ? KIND_ON : KIND_OFF;
        end else if (roll < status_end) begin
            req.kind = KIND_STATUS;
        end else begin
            req.kind = $urandom_range(1) ? KIND_RSVD_A : KIND_RSVD_B;
        end
        return req;
    endfunction

    // Tick until the running effect and the command queue are both done.
    task automatic settle_effects();
        while (board.busy() || board.backlog() != 0)
            offer(req_of(($urandom_range(15) == 0) ? KIND_STATUS : KIND_TICK,
                         COLOR_W'($urandom())));
    endtask

    task automatic run_random(input int unsigned count, input int unsigned w_scroll,
                              input int unsigned w_dimm);
        int unsigned k;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) wait_results(0);   // full pause mid-phase
            offer(pick_request(w_scroll, w_dimm));
        end
        settle_effects();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [KIND_W-1:0]     fill_kind [11];
        logic [CFG_DATA_W-1:0] junk;
        int unsigned           k;

        fill_kind = '{KIND_ON, KIND_OFF, KIND_SCROLL, KIND_ON, KIND_OFF, KIND_ON,
                      KIND_OFF, KIND_SCROLL, KIND_ON, KIND_OFF, KIND_ON};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: plain on/off/status, ignored kinds, idle tick
        offer(req_of(KIND_STATUS, '0));
        offer(req_of(KIND_ON, WHITE));
        offer(req_of(KIND_ON, '0));
        offer(req_of(KIND_OFF, 24'h5A5A5A));
        offer(req_of(KIND_RSVD_A, WHITE));
        offer(req_of(KIND_RSVD_B, 24'h000001));
        offer(req_of(KIND_TICK, WHITE));
        offer(req_of(KIND_STATUS, WHITE));
        offer(req_of(KIND_ON, 24'h123456));
        run_random(20, 0, 0);

        // widest strip, fastest scroll, single sweep: mask walks past bit 31.
        // Eleven commands during the sweep overflow the queue by one.
        wait_results(DRAIN_CYCLES);
        write_register(CFG_LED_COUNT, 16'd32);
        write_register(CFG_SCROLL_STEP, 16'd1);
        write_register(CFG_SCROLL_DUR, 16'd1);
        offer(req_of(KIND_SCROLL, 24'hA5C3E1));
        for (k = 0; k < 11; k++) offer(req_of(fill_kind[k], COLOR_W'($urandom())));
        offer(req_of(KIND_STATUS, '0));
        run_random(40, 10, 0);

        // zero registers: one LED, step as one, scroll ends at once with no frame;
        // dimm on the green channel only runs its full three rounds
        wait_results(DRAIN_CYCLES);
        write_register(CFG_LED_COUNT, 16'd0);
        write_register(CFG_SCROLL_STEP, 16'd0);
        write_register(CFG_SCROLL_DUR, 16'd0);
        offer(req_of(KIND_SCROLL, COLOR_W'($urandom())));
        offer(req_of(KIND_STATUS, '0));
        offer(req_of(KIND_ON, GREEN_MASK));
        offer(req_of(KIND_DIMM, '0));
        run_random(30, 30, 5);

        // oversize count clamps to the max; receiver holds off while the
        // sender keeps going, so the block backs up
        wait_results(DRAIN_CYCLES);
        write_register(CFG_LED_COUNT, 16'h003F);
        write_register(CFG_SCROLL_STEP, 16'h00FF);
        write_register(CFG_SCROLL_DUR, 16'hFFFF);
        @(posedge clk);
        hold_off_req = 1'b1;
        repeat (30) offer(pick_request(0, 0));
        run_random(20, 0, 0);

        // single LED, slowest scroll; upper write bits carry garbage
        wait_results(DRAIN_CYCLES);
        junk = CFG_DATA_W'($urandom());
        write_register(CFG_LED_COUNT, {junk[15:6], 6'd1});
        write_register(CFG_SCROLL_STEP, {junk[15:8], 8'hFF});
        write_register(CFG_SCROLL_DUR, 16'd1);
        offer(req_of(KIND_SCROLL, 24'h00FFFF));
        run_random(15, 10, 0);

        // mid settings, multiple sweeps per scroll, all command types
        wait_results(DRAIN_CYCLES);
        junk = CFG_DATA_W'($urandom());
        write_register(CFG_UNUSED, junk);
        write_register(CFG_LED_COUNT, {junk[15:6], 6'd7});
        write_register(CFG_SCROLL_STEP, {junk[15:8], 8'd3});
        write_register(CFG_SCROLL_DUR, 16'd40);
        run_random(50, 15, 3);

        wait_results(TAIL_CYCLES);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: led_strip_effect_sequencer_top.f
rtl/lses_pkg.sv
rtl/lses_ctrl.sv
rtl/lses_dp.sv
rtl/led_strip_effect_sequencer_top.sv
tb/testbench.sv
